@@ src/slsr_pkg.sv @@
// Shared types, constants and arithmetic helpers of the stick linearize and sector remap block.
// No dependencies; slsr_dp, slsr_ctrl and the top level import this package.
package slsr_pkg;

   localparam int SECTORS_DEF      = 8;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int CNT_W            = 5;
   localparam int XW               = 35;
   localparam int ZW               = 21;
   localparam int ACC_W            = 52;
   localparam int LIN_LEN          = 9;
   localparam int MAT_LEN          = 6;

   localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
   localparam logic signed [ZW-1:0] TWO_PI_Q16  = ZW'(411775);
   localparam logic signed [31:0]   COEF_ONE    = 32'sd65536;

   typedef enum logic [2:0] {
      MS_SS  = 3'd0,
      MS_P2S = 3'd1,
      MS_C3  = 3'd2,
      MS_C2  = 3'd3,
      MS_C1  = 3'd4,
      MS_MX  = 3'd5,
      MS_MY  = 3'd6
   } mul_sel_type;

   typedef struct packed {
      logic              tbl_wr;
      logic              cap;
      logic              axis;
      mul_sel_type       mul_sel;
      logic              p2_ld;
      logic              p3_ld;
      logic              acc_init;
      logic              acc_add;
      logic              l_ld;
      logic              cor_init;
      logic              cor_step;
      logic              ang_ld;
      logic              srch;
      logic              sa_ld;
      logic              ox_ld;
      logic              oy_ld;
      logic              out_ld;
      logic [1:0]        elem;
      logic [CNT_W-1:0]  cnt;
   } cmd_type;

   function automatic logic signed [17:0] atan_q16(input logic [CNT_W-1:0] i);
      logic signed [17:0] r;
      case (i)
         5'd0:    r = 18'sd51472;
         5'd1:    r = 18'sd30386;
         5'd2:    r = 18'sd16055;
         5'd3:    r = 18'sd8150;
         5'd4:    r = 18'sd4091;
         5'd5:    r = 18'sd2047;
         5'd6:    r = 18'sd1024;
         5'd7:    r = 18'sd512;
         5'd8:    r = 18'sd256;
         5'd9:    r = 18'sd128;
         5'd10:   r = 18'sd64;
         5'd11:   r = 18'sd32;
         5'd12:   r = 18'sd16;
         5'd13:   r = 18'sd8;
         5'd14:   r = 18'sd4;
         5'd15:   r = 18'sd2;
         5'd16:   r = 18'sd1;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-16:0] v);
      logic signed [31:0] r;
      if (v > 37'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -37'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [7:0] clamp_out(input logic signed [64:0] s);
      logic signed [7:0]  r;
      logic signed [32:0] q;
      q = s[64:32];
      if (s >= 65'sd545460846592)
         r = 8'sd127;
      else if (s <= -65'sd549755813888)
         r = -8'sd128;
      else if (s[64] && (s[31:0] != 32'd0))
         r = q[7:0] + 8'sd1;
      else
         r = q[7:0];
      return r;
   endfunction

endpackage

@@ src/slsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ src/slsr_dp.sv @@
// Datapath: coefficient registers, shared multiplier, polynomial accumulator, CORDIC,
// sector search and affine output. Depends on slsr_pkg and slsr_ram.
module slsr_dp #(
   parameter int SECTORS = slsr_pkg::SECTORS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  slsr_pkg::cmd_type   cmd,
   input  logic                csr_we,
   input  logic [2:0]          csr_addr,
   input  logic [31:0]         csr_wdata,
   input  logic signed [15:0]  req_sample_x,
   input  logic signed [15:0]  req_sample_y,
   input  logic [5:0]          req_table_index,
   input  logic signed [31:0]  req_table_value,
   output logic signed [7:0]   rsp_out_x,
   output logic signed [7:0]   rsp_out_y,
   output logic [2:0]          rsp_sector
);
   import slsr_pkg::*;

   localparam int SW = $clog2(SECTORS);
   localparam int AW = SW + 2;

   logic signed [31:0]    coef_ff [8];
   logic signed [15:0]    sx_ff, sy_ff;
   logic signed [63:0]    prod_ff;
   logic signed [16:0]    p2_ff, p3_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [31:0]    lx_ff, ly_ff;
   logic signed [XW-1:0]  x_ff, y_ff;
   logic signed [ZW-1:0]  z_ff, ang_ff;
   logic                  zero_ff;
   logic signed [31:0]    bnd_ff [SECTORS];
   logic [SW-1:0]         region_ff;
   logic                  found_ff;
   logic signed [63:0]    sa_ff;
   logic signed [7:0]     ox_ff, oy_ff;

   logic signed [15:0]    s;
   logic signed [31:0]    a_op, b_op;
   logic signed [31:0]    ram_rdata;
   logic [6:0]            widx;
   logic                  ram_we;
   logic signed [XW-1:0]  lx_ext, ly_ext, dx, dy;
   logic signed [ZW-1:0]  zv;
   logic signed [64:0]    aff_sum;
   logic [SW-1:0]         sidx;

   assign s      = cmd.axis ? sy_ff : sx_ff;
   assign widx   = {1'b0, req_table_index} - 7'(SECTORS);
   assign ram_we = cmd.tbl_wr && (int'(req_table_index) >= SECTORS)
                   && (int'(req_table_index) < 5 * SECTORS);
   assign lx_ext = XW'(lx_ff);
   assign ly_ext = XW'(ly_ff);
   assign dx     = y_ff >>> cmd.cnt;
   assign dy     = x_ff >>> cmd.cnt;
   assign zv     = zero_ff ? '0 : z_ff;
   assign aff_sum = 65'(sa_ff) + 65'(prod_ff);
   assign sidx   = cmd.cnt[SW-1:0];

   slsr_ram #(.WIDTH(32), .DEPTH(4 * SECTORS)) u_matrix (
      .clock (clock),
      .we    (ram_we),
      .waddr (widx[AW-1:0]),
      .wdata (req_table_value),
      .raddr ({region_ff, cmd.elem}),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (cmd.mul_sel)
         MS_SS:   begin a_op = 32'(s);                         b_op = 32'(s);     end
         MS_P2S:  begin a_op = 32'(p2_ff);                     b_op = 32'(s);     end
         MS_C3:   begin a_op = cmd.axis ? coef_ff[4] : coef_ff[0]; b_op = 32'(p3_ff); end
         MS_C2:   begin a_op = cmd.axis ? coef_ff[5] : coef_ff[1]; b_op = 32'(p2_ff); end
         MS_C1:   begin a_op = cmd.axis ? coef_ff[6] : coef_ff[2]; b_op = 32'(s);     end
         MS_MX:   begin a_op = ram_rdata;                      b_op = lx_ff;      end
         MS_MY:   begin a_op = ram_rdata;                      b_op = ly_ff;      end
         default: begin a_op = '0;                             b_op = '0;         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[2] <= COEF_ONE;
         coef_ff[6] <= COEF_ONE;
      end else if (csr_we) begin
         coef_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && (int'(req_table_index) < SECTORS)) begin
         bnd_ff[req_table_index[SW-1:0]] <= req_table_value;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
      if (cmd.cap) begin
         sx_ff <= req_sample_x;
         sy_ff <= req_sample_y;
      end
      if (cmd.p2_ld) begin
         p2_ff <= prod_ff[31:15];
      end
      if (cmd.p3_ld) begin
         p3_ff <= prod_ff[31:15];
      end
      if (cmd.acc_init) begin
         acc_ff <= {ACC_W'(cmd.axis ? coef_ff[7] : coef_ff[3])} <<< 15;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
      end
      if (cmd.l_ld) begin
         if (cmd.axis) begin
            ly_ff <= sat32(acc_ff[ACC_W-1:15]);
         end else begin
            lx_ff <= sat32(acc_ff[ACC_W-1:15]);
         end
      end
      if (cmd.cor_init) begin
         zero_ff <= (lx_ff == 32'sd0) && (ly_ff == 32'sd0);
         if (lx_ff < 0) begin
            if (ly_ff >= 0) begin
               x_ff <= ly_ext;
               y_ff <= -lx_ext;
               z_ff <= HALF_PI_Q16;
            end else begin
               x_ff <= -ly_ext;
               y_ff <= lx_ext;
               z_ff <= -HALF_PI_Q16;
            end
         end else begin
            x_ff <= lx_ext;
            y_ff <= ly_ext;
            z_ff <= '0;
         end
      end else if (cmd.cor_step) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + ZW'(atan_q16(cmd.cnt));
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - ZW'(atan_q16(cmd.cnt));
         end
      end
      if (cmd.ang_ld) begin
         if (32'(zv) < bnd_ff[0]) begin
            ang_ff <= zv + TWO_PI_Q16;
         end else begin
            ang_ff <= zv;
         end
      end
      if (cmd.sa_ld) begin
         sa_ff <= prod_ff;
      end
      if (cmd.ox_ld) begin
         ox_ff <= clamp_out(aff_sum);
      end
      if (cmd.oy_ld) begin
         oy_ff <= clamp_out(aff_sum);
      end
      if (cmd.out_ld) begin
         rsp_out_x  <= ox_ff;
         rsp_out_y  <= oy_ff;
         rsp_sector <= 3'(region_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= '0;
         found_ff  <= 1'b0;
      end else if (cmd.ang_ld) begin
         region_ff <= '0;
         found_ff  <= 1'b0;
      end else if (cmd.srch && !found_ff && (32'(ang_ff) < bnd_ff[sidx])) begin
         region_ff <= sidx;
         found_ff  <= 1'b1;
      end
   end

endmodule

@@ src/slsr_ctrl.sv @@
// Controller: one-hot sequencer that steps the datapath through linearize, CORDIC,
// sector search and affine phases, and owns the request/response handshake. Depends on slsr_pkg.
module slsr_ctrl #(
   parameter int SECTORS      = slsr_pkg::SECTORS_DEF,
   parameter int CORDIC_STEPS = slsr_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_operation,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slsr_pkg::cmd_type cmd
);
   import slsr_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_LIN   = 8'b0000_0010,
      S_CINIT = 8'b0000_0100,
      S_CSTEP = 8'b0000_1000,
      S_ANG   = 8'b0001_0000,
      S_SRCH  = 8'b0010_0000,
      S_MAT   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] ph;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.cnt      = cnt_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ph           = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation) begin
                  cmd.tbl_wr = 1'b1;
               end else begin
                  cmd.cap  = 1'b1;
                  state_in = S_LIN;
                  cnt_in   = '0;
               end
            end
         end
         S_LIN: begin
            cmd.axis = (cnt_ff >= CNT_W'(LIN_LEN));
            ph       = cmd.axis ? cnt_ff - CNT_W'(LIN_LEN) : cnt_ff;
            case (ph)
               5'd0: cmd.mul_sel = MS_SS;
               5'd1: cmd.p2_ld = 1'b1;
               5'd2: cmd.mul_sel = MS_P2S;
               5'd3: cmd.p3_ld = 1'b1;
               5'd4: begin
                  cmd.mul_sel  = MS_C3;
                  cmd.acc_init = 1'b1;
               end
               5'd5: begin
                  cmd.mul_sel = MS_C2;
                  cmd.acc_add = 1'b1;
               end
               5'd6: begin
                  cmd.mul_sel = MS_C1;
                  cmd.acc_add = 1'b1;
               end
               5'd7: cmd.acc_add = 1'b1;
               default: cmd.l_ld = 1'b1;
            endcase
            if (cnt_ff == CNT_W'(2 * LIN_LEN - 1)) begin
               state_in = S_CINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CINIT: begin
            cmd.cor_init = 1'b1;
            state_in     = S_CSTEP;
            cnt_in       = '0;
         end
         S_CSTEP: begin
            cmd.cor_step = 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = S_ANG;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ANG: begin
            cmd.ang_ld = 1'b1;
            state_in   = S_SRCH;
            cnt_in     = '0;
         end
         S_SRCH: begin
            cmd.srch = 1'b1;
            if (cnt_ff == CNT_W'(SECTORS - 1)) begin
               state_in = S_MAT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MAT: begin
            cmd.elem = cnt_ff[1:0];
            case (cnt_ff)
               5'd1: cmd.mul_sel = MS_MX;
               5'd2: begin
                  cmd.mul_sel = MS_MY;
                  cmd.sa_ld   = 1'b1;
               end
               5'd3: begin
                  cmd.mul_sel = MS_MX;
                  cmd.ox_ld   = 1'b1;
               end
               5'd4: begin
                  cmd.mul_sel = MS_MY;
                  cmd.sa_ld   = 1'b1;
               end
               5'd5: cmd.oy_ld = 1'b1;
               default: cmd.mul_sel = MS_SS;
            endcase
            if (cnt_ff == CNT_W'(MAT_LEN - 1)) begin
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/stick_linearize_sector_remap_top.sv @@
// Stick linearizer and sector remapper: top level joining controller, datapath and matrix RAM.
// Depends on slsr_pkg, slsr_ctrl and slsr_dp.
//
// Usage: the req_ channel carries one request per valid/ready handshake. A request with
// req_operation high writes one table word (boundary angles at index 0..SECTORS-1, matrix
// words after them) in the accept cycle and produces no response. A request with
// req_operation low is a stick sample; it produces one response on the rsp_ channel
// with the remapped x, y and the chosen sector. Load all table words before samples.
// The user writes coefficients on the csr_ port while no sample is in flight; not enforced.
// A sample passes through polynomial evaluation on one shared 32x32 multiplier, CORDIC
// init and min(CORDIC_STEPS,24) CORDIC steps, an unwrap step, a search over the SECTORS
// boundaries and the matrix steps, then the load of the output register.
// One sample is worked on at a time; the next request is taken in the idle cycle after the
// output load, which waits while an earlier response is still held and not yet taken;
// a table write leaves the block idle and ready for the next request.
// Reset clears the sequencer, drops rsp_valid and restores unity linear coefficients; the
// tables are undefined until written. While the receiver stalls, the response register
// holds its result and a new request is still taken; its result waits in the datapath.
module stick_linearize_sector_remap_top #(
   parameter int SECTORS      = slsr_pkg::SECTORS_DEF,
   parameter int CORDIC_STEPS = slsr_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,
   input  logic [5:0]         req_table_index,
   input  logic signed [31:0] req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [7:0]  rsp_out_x,
   output logic signed [7:0]  rsp_out_y,
   output logic [2:0]         rsp_sector,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata
);
   import slsr_pkg::*;

   cmd_type cmd;

   slsr_ctrl #(.SECTORS(SECTORS), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   slsr_dp #(.SECTORS(SECTORS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_sector      (rsp_sector)
   );

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_operation) |=> !req_ready)
      else $error("sample request did not start processing");

   a_table_wr_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation) |=> req_ready)
      else $error("table write left the block busy");

   a_rsp_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a sample in flight");

endmodule
